[sv/swa_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Sliding window average package
// Shared widths, controller state type and the command and status structs
// that join the controller to the datapath.
// ----------------------------------------------------------------------------
package swa_pkg;

  localparam int unsigned WINDOW_MAX   = 64;
  localparam int unsigned SAMPLE_WIDTH = 32;
  localparam int unsigned SLOT_W       = $clog2(WINDOW_MAX);
  localparam int unsigned COUNT_W      = SLOT_W + 1;
  localparam int unsigned SUM_W        = SAMPLE_WIDTH + SLOT_W;
  localparam int unsigned WIN_W        = 7;
  localparam int unsigned DIV_CNT_W    = $clog2(SUM_W);

  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(8);

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic        [COUNT_W-1:0]      count_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DROP,
    ST_DROP_SUB,
    ST_STORE,
    ST_START,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } swa_state_e;

  typedef struct packed {
    logic accept;
    logic drop_rd;
    logic drop_sub;
    logic store;
    logic div_start;
    logic scan_rd;
    logic load_out;
  } swa_cmd_t;

  typedef struct packed {
    logic full;
    logic scan_last;
    logic div_done;
    logic out_free;
  } swa_status_t;

endpackage : swa_pkg
`default_nettype wire

[sv/swa_in_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Sample input channel
// Valid/ready channel that carries one signed Q16.16 sample per transfer.
// ----------------------------------------------------------------------------
interface swa_in_if
  import swa_pkg::*;
();
  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface : swa_in_if
`default_nettype wire

[sv/swa_out_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Result output channel
// Valid/ready channel that carries average, swing and fill count.
// ----------------------------------------------------------------------------
interface swa_out_if
  import swa_pkg::*;
();
  logic                    valid;
  logic                    ready;
  sample_t                 window_average;
  logic [SAMPLE_WIDTH-1:0] max_swing;
  logic                    swing_valid;
  logic [WIN_W-1:0]        fill_count;

  modport source (output valid, output window_average, output max_swing,
                  output swing_valid, output fill_count, input ready);
  modport sink   (input valid, input window_average, input max_swing,
                  input swing_valid, input fill_count, output ready);
endinterface : swa_out_if
`default_nettype wire

[sv/swa_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Sliding window average divider
// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module swa_div
  import swa_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic signed [SUM_W-1:0] dividend_i,
  input  wire count_t                  divisor_i,
  output      logic                    done_o,
  output      sample_t                 quotient_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [SUM_W-1:0]     acc_q, acc_d;
  logic [COUNT_W:0]     rem_q, rem_d;
  count_t               dvs_q, dvs_d;
  logic                 neg_q, neg_d;
  logic [COUNT_W:0]     rem_sh;
  logic [SUM_W-1:0]     quot_mag;

  assign rem_sh = {rem_q[COUNT_W-1:0], acc_q[SUM_W-1]};

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      cnt_d  = '0;
      acc_d  = dividend_i[SUM_W-1] ? SUM_W'(-dividend_i) : SUM_W'(dividend_i);
      rem_d  = '0;
      dvs_d  = divisor_i;
      neg_d  = dividend_i[SUM_W-1];
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, dvs_q}) begin
        rem_d = rem_sh - {1'b0, dvs_q};
        acc_d = {acc_q[SUM_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        acc_d = {acc_q[SUM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(SUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign quot_mag   = neg_q ? (~acc_q + SUM_W'(1)) : acc_q;
  assign quotient_o = quot_mag[SAMPLE_WIDTH-1:0];
  assign done_o     = done_q;

endmodule : swa_div
`default_nettype wire

[sv/swa_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Sliding window average controller
// Sequences drop, store, swing scan and result load for one sample.
// ----------------------------------------------------------------------------
module swa_ctrl
  import swa_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire swa_status_t status_i,
  output      swa_cmd_t    cmd_o
);

  swa_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = status_i.full ? ST_DROP : ST_STORE;
        end
      end
      ST_DROP:     state_d = ST_DROP_SUB;
      ST_DROP_SUB: state_d = ST_STORE;
      ST_STORE:    state_d = ST_START;
      ST_START:    state_d = ST_SCAN;
      ST_SCAN: begin
        if (status_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN:    state_d = ST_FINISH;
      ST_FINISH: begin
        if (status_i.div_done && status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_DROP:     cmd_o.drop_rd   = 1'b1;
      ST_DROP_SUB: cmd_o.drop_sub  = 1'b1;
      ST_STORE:    cmd_o.store     = 1'b1;
      ST_START:    cmd_o.div_start = 1'b1;
      ST_SCAN:     cmd_o.scan_rd   = 1'b1;
      ST_DRAIN:    ;
      ST_FINISH:   cmd_o.load_out  = status_i.div_done && status_i.out_free;
      default:     ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule : swa_ctrl
`default_nettype wire

[sv/swa_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Sliding window average datapath
// Sample ring, running sum, swing scan, divider and output register.
// ----------------------------------------------------------------------------
module swa_datapath
  import swa_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [WIN_W-1:0] cfg_wdata_i,
  input  wire sample_t          sample_i,
  input  wire swa_cmd_t         cmd_i,
  output      swa_status_t      status_o,
  swa_out_if.source             out_o
);

  logic [SAMPLE_WIDTH-1:0] ring_q [WINDOW_MAX];
  logic [SAMPLE_WIDTH-1:0] rdata_q;
  logic [SLOT_W-1:0]       raddr;
  logic                    rd_en;

  logic [WIN_W-1:0]        window_q;
  logic [SLOT_W-1:0]       oldest_q, oldest_d;
  count_t                  held_q, held_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  sample_t                 sample_q;
  count_t                  win_eff;

  count_t                  scan_idx_q, scan_idx_d;
  logic                    rd_vld_q, rd_first_q;
  logic [SAMPLE_WIDTH-1:0] prev_q;
  logic [SAMPLE_WIDTH-1:0] max_q, max_d;
  logic signed [SAMPLE_WIDTH:0] diff;
  logic [SAMPLE_WIDTH:0]   diff_abs;

  logic                    div_done;
  sample_t                 div_quot;

  logic                    out_valid_q;
  sample_t                 avg_q;
  logic [SAMPLE_WIDTH-1:0] swing_q;
  logic                    swing_vld_q;
  logic [WIN_W-1:0]        fill_q;

  // Clamp the window register into 1..WINDOW_MAX.
  always_comb begin
    if (window_q == '0) begin
      win_eff = count_t'(1);
    end else if (window_q > WIN_W'(WINDOW_MAX)) begin
      win_eff = count_t'(WINDOW_MAX);
    end else begin
      win_eff = count_t'(window_q);
    end
  end

  assign rd_en = cmd_i.drop_rd || cmd_i.scan_rd;
  assign raddr = cmd_i.drop_rd ? oldest_q : (oldest_q + scan_idx_q[SLOT_W-1:0]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      ring_q[oldest_q + held_q[SLOT_W-1:0]] <= sample_q;
    end
    if (rd_en) begin
      rdata_q <= ring_q[raddr];
    end
  end

  always_comb begin
    oldest_d   = oldest_q;
    held_d     = held_q;
    sum_d      = sum_q;
    scan_idx_d = scan_idx_q;
    if (cfg_we_i) begin
      oldest_d = '0;
      held_d   = '0;
      sum_d    = '0;
    end else if (cmd_i.drop_sub) begin
      // drop the oldest sample
      sum_d    = sum_q - SUM_W'(signed'(rdata_q));
      oldest_d = oldest_q + SLOT_W'(1);
      held_d   = held_q - count_t'(1);
    end else if (cmd_i.store) begin
      sum_d  = sum_q + SUM_W'(sample_q);
      held_d = held_q + count_t'(1);
    end
    if (cmd_i.div_start) begin
      scan_idx_d = '0;
    end else if (cmd_i.scan_rd) begin
      scan_idx_d = scan_idx_q + count_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q   <= WINDOW_RESET;
      oldest_q   <= '0;
      held_q     <= '0;
      sum_q      <= '0;
      scan_idx_q <= '0;
      rd_vld_q   <= 1'b0;
      rd_first_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        window_q <= cfg_wdata_i;
      end
      oldest_q   <= oldest_d;
      held_q     <= held_d;
      sum_q      <= sum_d;
      scan_idx_q <= scan_idx_d;
      rd_vld_q   <= cmd_i.scan_rd;
      rd_first_q <= cmd_i.scan_rd && (scan_idx_q == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      sample_q <= sample_i;
    end
  end

  // Swing scan: one sample per cycle, compare against the previous one.
  assign diff     = $signed({rdata_q[SAMPLE_WIDTH-1], rdata_q})
                  - $signed({prev_q[SAMPLE_WIDTH-1], prev_q});
  assign diff_abs = diff[SAMPLE_WIDTH] ? (SAMPLE_WIDTH+1)'(-diff)
                                       : (SAMPLE_WIDTH+1)'(diff);

  always_comb begin
    max_d = max_q;
    if (cmd_i.div_start) begin
      max_d = '0;
    end else if (rd_vld_q && !rd_first_q) begin
      if (diff_abs[SAMPLE_WIDTH-1:0] > max_q) begin
        max_d = diff_abs[SAMPLE_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    max_q <= max_d;
    if (rd_vld_q) begin
      prev_q <= rdata_q;
    end
  end

  swa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (sum_q),
    .divisor_i  (held_q),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // Output register: hold the result until the transfer completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      avg_q       <= div_quot;
      swing_q     <= max_q;
      swing_vld_q <= (held_q >= count_t'(2));
      fill_q      <= WIN_W'(held_q);
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.window_average = avg_q;
  assign out_o.max_swing      = swing_q;
  assign out_o.swing_valid    = swing_vld_q;
  assign out_o.fill_count     = fill_q;

  assign status_o.full      = (held_q >= win_eff);
  assign status_o.scan_last = (scan_idx_q == held_q - count_t'(1));
  assign status_o.div_done  = div_done;
  assign status_o.out_free  = !out_valid_q || out_o.ready;

endmodule : swa_datapath
`default_nettype wire

[sv/sliding_window_average_and_swing_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Sliding window average and swing monitor
// Keeps the most recent samples in a ring and reports mean, swing and count.
// ----------------------------------------------------------------------------
// Flow: a full window first drops its oldest sample, then the new sample is
//   stored; the 38-step divider and the one-read-per-cycle ring scan over the
//   held samples follow, and no new sample is taken until the result is loaded.
// Reset: asynchronous, active low; history empty, window register at 8.
//   A window write also empties the history.
module sliding_window_average_and_swing_top
  import swa_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [WIN_W-1:0] cfg_wdata_i,
  swa_in_if.sink                in_i,
  swa_out_if.source             out_o
);

  swa_cmd_t    cmd;
  swa_status_t status;

  swa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  swa_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sample_i    (in_i.sample),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_o       (out_o)
  );

endmodule : sliding_window_average_and_swing_top
`default_nettype wire
